// ===== rtl/sctu_pkg.sv =====
// ----------------------------------------------------------------------------
// sctu_pkg
// Shared types and constants for the supervisor CSR and trap unit.
// ----------------------------------------------------------------------------
package sctu_pkg;

    localparam int XLEN = 32;

    // stream widths
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // csr numbers
    localparam logic [XLEN-1:0] CSR_SATP     = 32'h0000_0180;
    localparam logic [XLEN-1:0] CSR_SSTATUS  = 32'h0000_0100;
    localparam logic [XLEN-1:0] CSR_STVEC    = 32'h0000_0105;
    localparam logic [XLEN-1:0] CSR_SSCRATCH = 32'h0000_0140;
    localparam logic [XLEN-1:0] CSR_SEPC     = 32'h0000_0141;
    localparam logic [XLEN-1:0] CSR_SCAUSE   = 32'h0000_0142;

    localparam logic [XLEN-1:0] PRIV_SRET       = 32'h0000_0102;
    localparam logic [XLEN-1:0] CAUSE_EXT_INTR  = 32'h8000_0005;

    // sstatus bit positions
    localparam int SIE_POS  = 1;
    localparam int SPIE_POS = 5;

    typedef enum logic [1:0] {
        OP_CSR_SWAP = 2'd0,
        OP_TRAP     = 2'd1,
        OP_PRIV     = 2'd2,
        OP_POLL     = 2'd3
    } op_t;

    typedef struct packed {
        op_t             operation;
        logic [XLEN-1:0] immediate;
        logic            source_present;
        logic [XLEN-1:0] write_data;
        logic [XLEN-1:0] current_pc;
        logic            interrupt_request;
    } in_item_t;

    typedef struct packed {
        logic [XLEN-1:0] result_value;
        logic            interrupt_taken;
        logic            error;
    } out_item_t;

endpackage

// ===== rtl/sctu_core.sv =====
// ----------------------------------------------------------------------------
// sctu_core
// CSR state, trap entry, sret and interrupt poll for one registered beat.
// ----------------------------------------------------------------------------
module sctu_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  sctu_pkg::in_item_t          item,
    output sctu_pkg::out_item_t         result,
    output logic                        sie
);

    logic [sctu_pkg::XLEN-1:0] satp_reg,     satp_next;
    logic [sctu_pkg::XLEN-1:0] sstatus_reg,  sstatus_next;
    logic [sctu_pkg::XLEN-1:0] stvec_reg,    stvec_next;
    logic [sctu_pkg::XLEN-1:0] sscratch_reg, sscratch_next;
    logic [sctu_pkg::XLEN-1:0] sepc_reg,     sepc_next;
    logic [sctu_pkg::XLEN-1:0] scause_reg,   scause_next;
    logic                      pending_reg,  pending_next;

    logic                      pending_now;
    logic                      take_intr;
    logic [sctu_pkg::XLEN-1:0] status_trap;
    logic [sctu_pkg::XLEN-1:0] status_sret;

    assign sie         = sstatus_reg[sctu_pkg::SIE_POS];
    assign pending_now = pending_reg | item.interrupt_request;
    assign take_intr   = pending_now & sstatus_reg[sctu_pkg::SIE_POS];

    // trap: spie takes sie, sie cleared
    always_comb begin
        status_trap = sstatus_reg;
        status_trap[sctu_pkg::SPIE_POS] = sstatus_reg[sctu_pkg::SIE_POS];
        status_trap[sctu_pkg::SIE_POS]  = 1'b0;
    end

    // sret: sie takes spie, spie set
    always_comb begin
        status_sret = sstatus_reg;
        status_sret[sctu_pkg::SIE_POS]  = sstatus_reg[sctu_pkg::SPIE_POS];
        status_sret[sctu_pkg::SPIE_POS] = 1'b1;
    end

    always_comb begin
        satp_next     = satp_reg;
        sstatus_next  = sstatus_reg;
        stvec_next    = stvec_reg;
        sscratch_next = sscratch_reg;
        sepc_next     = sepc_reg;
        scause_next   = scause_reg;
        pending_next  = pending_now;
        result        = '0;

        case (item.operation)
            sctu_pkg::OP_CSR_SWAP: begin
                case (item.immediate)
                    sctu_pkg::CSR_SATP: begin
                        result.result_value = satp_reg;
                        if (item.source_present) satp_next = item.write_data;
                    end
                    sctu_pkg::CSR_SSTATUS: begin
                        result.result_value = sstatus_reg;
                        if (item.source_present) sstatus_next = item.write_data;
                    end
                    sctu_pkg::CSR_STVEC: begin
                        result.result_value = stvec_reg;
                        if (item.source_present) stvec_next = item.write_data;
                    end
                    sctu_pkg::CSR_SSCRATCH: begin
                        result.result_value = sscratch_reg;
                        if (item.source_present) sscratch_next = item.write_data;
                    end
                    sctu_pkg::CSR_SEPC: begin
                        result.result_value = sepc_reg;
                        if (item.source_present) sepc_next = item.write_data;
                    end
                    sctu_pkg::CSR_SCAUSE: begin
                        result.result_value = scause_reg;
                        if (item.source_present) scause_next = item.write_data;
                    end
                    default: begin
                        result.error = 1'b1;
                    end
                endcase
            end
            sctu_pkg::OP_TRAP: begin
                scause_next         = item.immediate;
                sepc_next           = item.write_data;
                sstatus_next        = status_trap;
                result.result_value = stvec_reg;
            end
            sctu_pkg::OP_PRIV: begin
                if (item.immediate == sctu_pkg::PRIV_SRET) begin
                    sstatus_next        = status_sret;
                    result.result_value = sepc_reg;
                end else begin
                    result.error = 1'b1;
                end
            end
            sctu_pkg::OP_POLL: begin
                if (take_intr) begin
                    pending_next           = 1'b0;
                    scause_next            = sctu_pkg::CAUSE_EXT_INTR;
                    sepc_next              = item.current_pc;
                    sstatus_next           = status_trap;
                    result.result_value    = stvec_reg;
                    result.interrupt_taken = 1'b1;
                end else begin
                    result.result_value = item.current_pc;
                end
            end
            default: begin
                result.error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            satp_reg     <= '0;
            sstatus_reg  <= '0;
            stvec_reg    <= '0;
            sscratch_reg <= '0;
            sepc_reg     <= '0;
            scause_reg   <= '0;
            pending_reg  <= 1'b0;
        end else if (step) begin
            satp_reg     <= satp_next;
            sstatus_reg  <= sstatus_next;
            stvec_reg    <= stvec_next;
            sscratch_reg <= sscratch_next;
            sepc_reg     <= sepc_next;
            scause_reg   <= scause_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

// ===== rtl/supervisor_csr_trap_unit.sv =====
// ----------------------------------------------------------------------------
// supervisor_csr_trap_unit
// Supervisor CSR file with trap entry, sret and interrupt polling.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request beat: tuser holds the operation and the
//   source-present flag, tdata the csr number / cause / privileged code,
//   write data, current pc and the interrupt request.
//   m_ channel returns one result beat per request: tdata is the old csr
//   value, trap vector, return pc or next pc; tuser flags an interrupt taken
//   and an error (unknown csr or privileged code).
//   The path has two register stages, the input register and the result
//   register; m_tvalid rises when a beat moves from the first to the second.
//   Throughput is one beat per cycle unless stalled; csr state is updated as each
//   beat leaves the input register, so beats are handled strictly in order.
//   When the receiver stalls, the result register holds and the input
//   register fills; s_tready drops only when both are full.
//   Reset clears all csrs, the interrupt pending latch and both valid flags.
// ----------------------------------------------------------------------------
module supervisor_csr_trap_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // immediate[31:0], write_data[63:32], current_pc[95:64],
    // interrupt_request[96], zero padding[103:97]
    input  logic [sctu_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0], source_present[2]
    input  logic [sctu_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_value[31:0]
    output logic [sctu_pkg::M_TDATA_W-1:0] m_tdata,
    // interrupt_taken[0], error[1]
    output logic [sctu_pkg::M_TUSER_W-1:0] m_tuser
);

    sctu_pkg::in_item_t  in_item_reg, in_item_next;
    logic                in_valid_reg, in_valid_next;
    sctu_pkg::out_item_t out_item_reg;
    logic                out_valid_reg, out_valid_next;
    sctu_pkg::out_item_t core_result;
    logic                core_sie;
    logic                s_accept;
    logic                advance;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    always_comb begin
        in_item_next.operation         = sctu_pkg::op_t'(s_tuser[1:0]);
        in_item_next.source_present    = s_tuser[2];
        in_item_next.immediate         = s_tdata[31:0];
        in_item_next.write_data        = s_tdata[63:32];
        in_item_next.current_pc        = s_tdata[95:64];
        in_item_next.interrupt_request = s_tdata[96];
    end

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    sctu_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .result  (core_result),
        .sie     (core_sie)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= in_item_next;
        end
        if (advance) begin
            out_item_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg.result_value;
    assign m_tuser  = {out_item_reg.error, out_item_reg.interrupt_taken};

`ifndef SYNTH
    // a taken interrupt is never reported as an error
    a_taken_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("interrupt taken and error on the same beat");

    // taking an interrupt must leave sie cleared
    a_taken_clears_sie: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && core_result.interrupt_taken) |=> !core_sie)
        else $error("sie still set after interrupt entry");

    // an interrupt is only taken with sie set
    a_taken_needs_sie: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && core_result.interrupt_taken) |-> core_sie)
        else $error("interrupt taken with sie clear");

    // nothing in flight straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("pipeline not empty after reset");
`endif

endmodule
